// ===== rtl/core/slqe_pkg.sv =====
package slqe_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam int BYTE_W = 8;
    localparam int IDX_W  = 3;

    // request kinds carried on s_tuser
    localparam logic [1:0] REQ_START    = 2'd0;
    localparam logic [1:0] REQ_DATA     = 2'd1;
    localparam logic [1:0] REQ_END_STR  = 2'd2;
    localparam logic [1:0] REQ_END_LIST = 2'd3;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;

    typedef enum logic [2:0] {
        SEQ_OPEN_FIRST,  // [ "
        SEQ_OPEN_NEXT,   // , space "
        SEQ_PAIR,        // backslash + data
        SEQ_HEX,         // \u00NN of data
        SEQ_PLAIN,       // data
        SEQ_QUOTE,       // "
        SEQ_EMPTY_LIST,  // [ ]
        SEQ_CLOSE_LIST   // ]
    } seq_code_t;

    typedef struct packed {
        seq_code_t         code;
        logic [BYTE_W-1:0] data;
    } seq_desc_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] d;
        if (nib < 4'd10) begin
            d = CH_ZERO + {4'd0, nib};
        end else begin
            d = CH_LOW_A + {4'd0, nib} - 8'd10;
        end
        return d;
    endfunction

    function automatic logic [IDX_W-1:0] seq_len(input seq_code_t code);
        logic [IDX_W-1:0] n;
        unique case (code)
            SEQ_OPEN_FIRST: n = 3'd2;
            SEQ_OPEN_NEXT:  n = 3'd3;
            SEQ_PAIR:       n = 3'd2;
            SEQ_HEX:        n = 3'd6;
            SEQ_PLAIN:      n = 3'd1;
            SEQ_QUOTE:      n = 3'd1;
            SEQ_EMPTY_LIST: n = 3'd2;
            SEQ_CLOSE_LIST: n = 3'd1;
            default:        n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] seq_byte(input seq_desc_t d, input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        b = d.data;
        unique case (d.code)
            SEQ_OPEN_FIRST: b = (idx == 3'd0) ? CH_LBRACK : CH_QUOTE;
            SEQ_OPEN_NEXT: begin
                unique case (idx)
                    3'd0:    b = CH_COMMA;
                    3'd1:    b = CH_SPACE;
                    default: b = CH_QUOTE;
                endcase
            end
            SEQ_PAIR:       b = (idx == 3'd0) ? CH_BSLASH : d.data;
            SEQ_HEX: begin
                unique case (idx)
                    3'd0:    b = CH_BSLASH;
                    3'd1:    b = CH_LOW_U;
                    3'd2:    b = CH_ZERO;
                    3'd3:    b = CH_ZERO;
                    3'd4:    b = hex_digit(d.data[7:4]);
                    default: b = hex_digit(d.data[3:0]);
                endcase
            end
            SEQ_PLAIN:      b = d.data;
            SEQ_QUOTE:      b = CH_QUOTE;
            SEQ_EMPTY_LIST: b = (idx == 3'd0) ? CH_LBRACK : CH_RBRACK;
            SEQ_CLOSE_LIST: b = CH_RBRACK;
            default:        b = d.data;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/core/string_list_quote_escaper.sv =====
// channel | ports                  | contents
// --------+------------------------+---------------------------------------------
// input   | s_tvalid/tready/tuser  | s_tuser[1:0] req_type, s_tdata[7:0] in_byte
// output  | m_tvalid/tready/tlast  | m_tdata[7:0] out_byte, m_tlast last
//
// one output byte per cycle while m_tready is high; an input transaction yields 1 to 6 bytes, so the
// input runs at one per cycle for plain bytes and the output register sets the rate
// the classifier writes a descriptor queue (QueueDepth entries); the emitter steps
// through each descriptor's bytes, so a long escape holds input once the queue fills
// synchronous active-low reset clears the list state, the queue and the emitter
// either side may stall at any time without loss
module string_list_quote_escaper #(
    parameter int QueueDepth = slqe_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast
);
    import slqe_pkg::*;

    logic      wr_valid;
    logic      wr_ready;
    seq_desc_t wr_desc;
    logic      rd_valid;
    logic      rd_ready;
    seq_desc_t rd_desc;

    slqe_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_kind  (s_tuser),
        .in_data  (s_tdata),
        .q_valid  (wr_valid),
        .q_ready  (wr_ready),
        .q_desc   (wr_desc)
    );

    slqe_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr_desc  (wr_desc),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd_desc  (rd_desc)
    );

    slqe_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (rd_valid),
        .q_ready   (rd_ready),
        .q_desc    (rd_desc),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// ===== rtl/core/slqe_front.sv =====
module slqe_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              in_kind,
    input  logic [7:0]              in_data,
    output logic                    q_valid,
    input  logic                    q_ready,
    output slqe_pkg::seq_desc_t     q_desc
);
    import slqe_pkg::*;

    logic any_seen_reg;
    logic any_seen_next;
    logic take;

    assign in_ready = q_ready;
    assign q_valid  = in_valid;
    assign take     = in_valid & q_ready;

    always_comb begin
        q_desc.data = in_data;
        q_desc.code = SEQ_PLAIN;
        any_seen_next = any_seen_reg;
        unique case (in_kind)
            REQ_START: begin
                q_desc.code = any_seen_reg ? SEQ_OPEN_NEXT : SEQ_OPEN_FIRST;
                any_seen_next = 1'b1;
            end
            REQ_DATA: begin
                q_desc.code = SEQ_PAIR;
                unique case (in_data)
                    CH_QUOTE:  q_desc.data = CH_QUOTE;
                    CH_BSLASH: q_desc.data = CH_BSLASH;
                    8'h0A:     q_desc.data = CH_LOW_N;
                    8'h0D:     q_desc.data = CH_LOW_R;
                    8'h09:     q_desc.data = CH_LOW_T;
                    8'h08:     q_desc.data = CH_LOW_B;
                    8'h0C:     q_desc.data = CH_LOW_F;
                    default: begin
                        // remaining control bytes, zero included, take the long form
                        q_desc.code = (in_data < 8'h20) ? SEQ_HEX : SEQ_PLAIN;
                    end
                endcase
            end
            REQ_END_STR: q_desc.code = SEQ_QUOTE;
            REQ_END_LIST: begin
                q_desc.code = any_seen_reg ? SEQ_CLOSE_LIST : SEQ_EMPTY_LIST;
                any_seen_next = 1'b0;
            end
            default: q_desc.code = SEQ_QUOTE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            any_seen_reg <= 1'b0;
        end else if (take) begin
            any_seen_reg <= any_seen_next;
        end
    end

endmodule

// ===== rtl/core/slqe_queue.sv =====
module slqe_queue #(
    parameter int Depth = slqe_pkg::QUEUE_DEPTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    wr_valid,
    output logic                    wr_ready,
    input  slqe_pkg::seq_desc_t     wr_desc,
    output logic                    rd_valid,
    input  logic                    rd_ready,
    output slqe_pkg::seq_desc_t     rd_desc
);
    import slqe_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    seq_desc_t         mem [Depth];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [CntW-1:0]   count_reg;
    logic              push;
    logic              pop;

    assign wr_ready = (count_reg != FullCnt);
    assign rd_valid = (count_reg != '0);
    assign rd_desc  = mem[rd_ptr_reg];
    assign push     = wr_valid & wr_ready;
    assign pop      = rd_valid & rd_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/slqe_back.sv =====
module slqe_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_valid,
    output logic                    q_ready,
    input  slqe_pkg::seq_desc_t     q_desc,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [7:0]              out_byte,
    output logic                    out_last
);
    import slqe_pkg::*;

    seq_desc_t          cur_reg;
    logic               cur_valid_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               out_last_reg;

    seq_desc_t          src;
    logic               src_valid;
    logic [IDX_W-1:0]   src_idx;
    logic               src_last;
    logic               advance;

    // a sequence in progress takes priority over the queue head
    assign src       = cur_valid_reg ? cur_reg : q_desc;
    assign src_valid = cur_valid_reg | q_valid;
    assign src_idx   = cur_valid_reg ? idx_reg : '0;
    assign src_last  = (src_idx == seq_len(src.code) - 3'd1);
    assign advance   = ~out_valid_reg | out_ready;
    assign q_ready   = ~cur_valid_reg & advance;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= src_valid;
            if (src_valid) begin
                cur_valid_reg <= ~src_last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && src_valid) begin
            out_byte_reg <= seq_byte(src, src_idx);
            out_last_reg <= src_last;
            cur_reg      <= src;
            idx_reg      <= src_idx + 3'd1;
        end
    end

endmodule

// ===== dv/string_list_quote_escaper_tb.sv =====
module string_list_quote_escaper_tb;
    import slqe_pkg::*;

    localparam int CycleLimit  = 200000;
    localparam int RandomItems = 120;
    localparam int DrainCycles = 20;
    localparam string HexChars = "0123456789abcdef";

    typedef struct {
        logic [7:0] out_byte;
        logic       last;
    } text_byte_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] in_byte
    logic [1:0] s_tuser = 2'b00;   // [1:0] req_type
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] out_byte
    logic       m_tlast;

    text_byte_t rendered_q[$];
    logic       list_started = 1'b0;
    int         errors = 0;
    int         items_sent = 0;
    int         cycles = 0;
    bit         no_idle = 1'b0;

    string_list_quote_escaper uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic void push_text(input logic [7:0] b);
        text_byte_t t;
        t.out_byte = b;
        t.last = 1'b0;
        rendered_q.push_back(t);
    endfunction

    // expected text for one accepted request; the final byte carries last
    function automatic void render_request(input logic [1:0] kind, input logic [7:0] c);
        logic [7:0] pair;
        pair = 8'h00;
        case (kind)
            REQ_START: begin
                if (!list_started) begin
                    push_text(CH_LBRACK);
                end else begin
                    push_text(CH_COMMA);
                    push_text(CH_SPACE);
                end
                push_text(CH_QUOTE);
                list_started = 1'b1;
            end
            REQ_DATA: begin
                case (c)
                    CH_QUOTE:  pair = CH_QUOTE;
                    CH_BSLASH: pair = CH_BSLASH;
                    8'h0A:     pair = CH_LOW_N;
                    8'h0D:     pair = CH_LOW_R;
                    8'h09:     pair = CH_LOW_T;
                    8'h08:     pair = CH_LOW_B;
                    8'h0C:     pair = CH_LOW_F;
                    default:   pair = 8'h00;
                endcase
                if (pair != 8'h00) begin
                    push_text(CH_BSLASH);
                    push_text(pair);
                end else if (c < 8'h20) begin
                    push_text(CH_BSLASH);
                    push_text(CH_LOW_U);
                    push_text(CH_ZERO);
                    push_text(CH_ZERO);
                    push_text(HexChars[c[7:4]]);
                    push_text(HexChars[c[3:0]]);
                end else begin
                    push_text(c);
                end
            end
            REQ_END_STR: push_text(CH_QUOTE);
            default: begin
                if (!list_started) begin
                    push_text(CH_LBRACK);
                end
                push_text(CH_RBRACK);
                list_started = 1'b0;
            end
        endcase
        rendered_q[rendered_q.size()-1].last = 1'b1;
    endfunction

    // prediction on the input side first, so a same-edge result always finds its expectation
    always @(posedge aclk) begin
        text_byte_t want;
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("%0t timeout with %0d bytes outstanding", $time, rendered_q.size());
            $display("** string_list_quote_escaper: FAILED **");
            $finish;
        end
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                render_request(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (rendered_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected transaction: expected none, actual byte %h last %b",
                             $time, m_tdata, m_tlast);
                end else begin
                    want = rendered_q.pop_front();
                    if (m_tdata !== want.out_byte) begin
                        errors++;
                        $display("%0t out_byte mismatch: expected %h, actual %h",
                                 $time, want.out_byte, m_tdata);
                    end
                    if (m_tlast !== want.last) begin
                        errors++;
                        $display("%0t last mismatch: expected %b, actual %b",
                                 $time, want.last, m_tlast);
                    end
                end
            end
        end
    end

    // result side back-pressure, one draw per transaction
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
                m_tready <= 1'b1;
            end
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic send_req(input logic [1:0] kind, input logic [7:0] data);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    function automatic logic [7:0] pick_text_byte();
        logic [7:0] specials[7] = '{CH_QUOTE, CH_BSLASH, 8'h0A, 8'h0D, 8'h09, 8'h08, 8'h0C};
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0:       b = specials[$urandom_range(0, 6)];
            1:       b = 8'($urandom_range(0, 31));
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    task automatic test_empty_lists();
        send_req(REQ_END_LIST, 8'hFF);
        send_req(REQ_END_LIST, 8'h00);
    endtask

    task automatic test_escapes();
        logic [7:0] cases[14] = '{8'h22, 8'h5C, 8'h0A, 8'h0D, 8'h09, 8'h08, 8'h0C,
                                  8'h00, 8'h1F, 8'h01, 8'h20, 8'h7F, 8'hFF, 8'h41};
        send_req(REQ_START, 8'hA5);
        foreach (cases[i]) send_req(REQ_DATA, cases[i]);
        send_req(REQ_END_STR, 8'h5A);
        send_req(REQ_END_LIST, 8'h3C);
    endtask

    // data and closing quote with no open string, then a start inside an open string
    task automatic test_loose_sequences();
        send_req(REQ_DATA, 8'h0B);
        send_req(REQ_END_STR, 8'h00);
        send_req(REQ_START, 8'hFF);
        send_req(REQ_START, 8'h00);
        send_req(REQ_END_STR, 8'hFF);
        send_req(REQ_END_LIST, 8'hFF);
    endtask

    task automatic test_random_lists();
        int target;
        int n_str;
        int n_bytes;
        target = items_sent + RandomItems;
        while (items_sent < target) begin
            if ($urandom_range(0, 7) == 0) begin
                no_idle = ~no_idle;
            end
            if ($urandom_range(0, 9) == 0) begin
                send_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end else begin
                n_str = $urandom_range(0, 4);
                repeat (n_str) begin
                    send_req(REQ_START, 8'($urandom_range(0, 255)));
                    n_bytes = $urandom_range(0, 6);
                    repeat (n_bytes) send_req(REQ_DATA, pick_text_byte());
                    if ($urandom_range(0, 15) != 0) begin
                        send_req(REQ_END_STR, 8'($urandom_range(0, 255)));
                    end
                end
                send_req(REQ_END_LIST, 8'($urandom_range(0, 255)));
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_lists();
        test_escapes();
        test_loose_sequences();
        test_random_lists();
        s_tvalid <= 1'b0;
        while (rendered_q.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
        if (errors == 0) begin
            $display("** string_list_quote_escaper: PASSED **");
        end else begin
            $display("** string_list_quote_escaper: FAILED **");
        end
        $finish;
    end

endmodule
